[rtl/utf8_to_utf16_transcoder_defines.svh]
// assertion helpers, included by u8u16_back
`ifndef UTF8_TO_UTF16_TRANSCODER_DEFINES_SVH
`define UTF8_TO_UTF16_TRANSCODER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define U8U16_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("u8u16 check failed");

// antecedent implies consequent in the next cycle
`define U8U16_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("u8u16 check failed");

`endif

[rtl/u8u16_pkg.sv]
`default_nettype none

package u8u16_pkg;

  // string length limit; byte and unit counters wrap at this value
  localparam int MAX_STRING_BYTES = 65536;
  localparam int POS_W = $clog2(MAX_STRING_BYTES);

  // width of the offset and index fields on the result stream
  localparam int FIELD_W = 16;
  localparam int UNIT_W  = 16;
  localparam int CP_W    = 21;

  // queue between decoder and unit emitter
  localparam int FIFO_AW    = 2;
  localparam int FIFO_DEPTH = 1 << FIFO_AW;

  // result stream packing: unit, offset, index, run_last, zero pad
  localparam int M_TDATA_W = 56;

  // utf-8 byte classes
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_CODE = 8'hF0;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_CODE  = 8'h80;
  localparam int         CONT_BITS  = 6;

  // utf-16 surrogate constants
  localparam logic [CP_W-1:0]   BMP_MAX   = 21'h0FFFF;
  localparam logic [CP_W-1:0]   SUPP_BASE = 21'h10000;
  localparam logic [UNIT_W-1:0] HI_SURR   = 16'hD800;
  localparam logic [UNIT_W-1:0] LO_SURR   = 16'hDC00;

  // one decoded byte's worth of results
  typedef struct packed {
    logic [UNIT_W-1:0] unit_hi;  // sole unit, or high surrogate
    logic [UNIT_W-1:0] unit_lo;  // low surrogate of a pair
    logic [POS_W-1:0]  offset;
    logic [POS_W-1:0]  index;    // index of the first unit
    logic              pair;
    logic              err;
    logic              eos;
  } op_t;

  // position counter step with wrap at the string limit
  function automatic logic [POS_W-1:0] pos_inc(input logic [POS_W-1:0] v);
    logic [POS_W-1:0] r;
    if (v == POS_W'(MAX_STRING_BYTES - 1)) r = '0;
    else r = v + POS_W'(1);
    return r;
  endfunction

  // low bits of a position as a result field
  function automatic logic [FIELD_W-1:0] pos_field(input logic [POS_W-1:0] v);
    logic [POS_W+FIELD_W-1:0] w;
    w = {{FIELD_W{1'b0}}, v};
    return w[FIELD_W-1:0];
  endfunction

endpackage

`default_nettype wire

[rtl/utf8_to_utf16_transcoder.sv]
// channel  | dir | valid/ready        | tdata                               | tuser/tlast
// ---------+-----+--------------------+-------------------------------------+----------------------
// s        | in  | s_tvalid, s_tready | [7:0] data_byte                     | tlast end_of_string
// m        | out | m_tvalid, m_tready | [15:0] unit [31:16] offset [47:32]  | tuser is_error,
//          |     |                    | index [48] run_last                 | tlast string_done
//
// one byte is taken per cycle while the queue has room; a byte that gives results is written
// into the queue and then into the output register, and a surrogate pair goes out as a high
// and then a low surrogate item; a four-entry queue separates the decoder from the unit
// emitter, so the input stalls only when that queue is full
// rst is synchronous and returns the decoder, queue and output to empty

`default_nettype none

module utf8_to_utf16_transcoder
  import u8u16_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [7:0]           s_tdata,   // [7:0] data_byte
  input  wire logic                 s_tlast,   // end_of_string
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [M_TDATA_W-1:0]      m_tdata,   // [15:0] code_unit, [31:16] char_byte_offset,
                                               // [47:32] unit_index, [48] run_last, zero pad
  output logic                      m_tuser,   // is_error
  output logic                      m_tlast    // string_done
);

  logic q_full;
  logic q_push;
  op_t  q_op;
  logic q_pop;
  op_t  q_head;
  logic q_empty;

  // byte decoder
  u8u16_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_op     (q_op)
  );

  // decoded result queue
  u8u16_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_op (q_op),
    .full    (q_full),
    .pop     (q_pop),
    .head    (q_head),
    .empty   (q_empty)
  );

  // code unit emitter
  u8u16_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (q_head),
    .empty    (q_empty),
    .pop      (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

[rtl/u8u16_front.sv]
`default_nettype none

module u8u16_front
  import u8u16_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] data_byte
  input  wire logic       s_tlast,   // end_of_string
  input  wire logic       q_full,
  output logic            q_push,
  output op_t             q_op
);

  logic [1:0]       need, need_next;
  logic [CP_W-1:0]  part, part_next;
  logic [POS_W-1:0] pos, pos_next;
  logic [POS_W-1:0] seq, seq_next;
  logic [POS_W-1:0] units, units_next;
  logic             skip, skip_next;

  logic             acc;
  logic             emit;
  logic             err;
  logic [POS_W-1:0] err_offs;
  logic [CP_W-1:0]  cp_acc;
  logic [CP_W-1:0]  supp;
  logic             is_cont;

  assign s_tready = !q_full;
  assign acc      = s_tvalid && s_tready;
  assign cp_acc   = {part[CP_W-CONT_BITS-1:0], s_tdata[CONT_BITS-1:0]};
  assign supp     = cp_acc - SUPP_BASE;
  assign is_cont  = (s_tdata & CONT_MASK) == CONT_CODE;

  // decode one byte and work out the decoder state after it
  always_comb begin
    need_next  = need;
    part_next  = part;
    pos_next   = pos;
    seq_next   = seq;
    units_next = units;
    skip_next  = skip;
    emit       = 1'b0;
    err        = 1'b0;
    err_offs   = pos;
    q_op       = '0;

    if (skip) begin
      // drop bytes until end of string
      if (s_tlast) begin
        need_next  = '0;
        part_next  = '0;
        pos_next   = '0;
        seq_next   = '0;
        units_next = '0;
        skip_next  = 1'b0;
      end else begin
        pos_next = pos_inc(pos);
      end
    end else begin
      if (need == 2'd0) begin
        // lead byte
        seq_next = pos;
        priority if (!s_tdata[7]) begin
          emit           = 1'b1;
          q_op.unit_hi   = {8'h00, s_tdata};
        end else if ((s_tdata & LEAD2_MASK) == LEAD2_CODE) begin
          need_next = 2'd1;
          part_next = {16'h0000, s_tdata[4:0]};
        end else if ((s_tdata & LEAD3_MASK) == LEAD3_CODE) begin
          need_next = 2'd2;
          part_next = {17'h00000, s_tdata[3:0]};
        end else if ((s_tdata & LEAD4_MASK) == LEAD4_CODE) begin
          need_next = 2'd3;
          part_next = {18'h00000, s_tdata[2:0]};
        end else begin
          err      = 1'b1;
          err_offs = pos;
        end
      end else if (!is_cont) begin
        err      = 1'b1;
        err_offs = seq;
      end else begin
        // continuation byte
        part_next = cp_acc;
        need_next = need - 2'd1;
        if (need == 2'd1) begin
          emit      = 1'b1;
          part_next = '0;
          if (cp_acc > BMP_MAX) begin
            q_op.pair    = 1'b1;
            q_op.unit_hi = HI_SURR | {5'b00000, supp[CP_W-1:10]};
            q_op.unit_lo = LO_SURR | {6'b000000, supp[9:0]};
          end else begin
            q_op.unit_hi = cp_acc[UNIT_W-1:0];
          end
        end
      end

      // string ends inside a sequence
      if (!err && s_tlast && need_next != 2'd0) begin
        err      = 1'b1;
        err_offs = seq_next;
      end

      q_op.offset = seq_next;
      q_op.index  = units;
      q_op.eos    = s_tlast;

      if (err) begin
        q_op.err     = 1'b1;
        q_op.offset  = err_offs;
        q_op.unit_hi = '0;
        q_op.unit_lo = '0;
        q_op.pair    = 1'b0;
        skip_next    = 1'b1;
        need_next    = '0;
        part_next    = '0;
      end else if (emit) begin
        units_next = q_op.pair ? pos_inc(pos_inc(units)) : pos_inc(units);
      end

      // end of string returns everything to reset
      if (s_tlast) begin
        need_next  = '0;
        part_next  = '0;
        pos_next   = '0;
        seq_next   = '0;
        units_next = '0;
        skip_next  = 1'b0;
      end else begin
        pos_next = pos_inc(pos);
      end
    end
  end

  assign q_push = acc && !skip && (err || emit);

  // decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      need  <= '0;
      part  <= '0;
      pos   <= '0;
      seq   <= '0;
      units <= '0;
      skip  <= 1'b0;
    end else if (acc) begin
      need  <= need_next;
      part  <= part_next;
      pos   <= pos_next;
      seq   <= seq_next;
      units <= units_next;
      skip  <= skip_next;
    end
  end

endmodule

`default_nettype wire

[rtl/u8u16_fifo.sv]
`default_nettype none

module u8u16_fifo
  import u8u16_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire op_t  push_op,
  output logic      full,
  input  wire logic pop,
  output op_t       head,
  output logic      empty
);

  op_t                slots [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;

  assign full  = count == (FIFO_AW+1)'(FIFO_DEPTH);
  assign empty = count == '0;
  assign head  = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + FIFO_AW'(1);
      if (pop)  rd_ptr <= rd_ptr + FIFO_AW'(1);
      unique case ({push, pop})
        2'b10:   count <= count + (FIFO_AW+1)'(1);
        2'b01:   count <= count - (FIFO_AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_op;
  end

endmodule

`default_nettype wire

[rtl/u8u16_back.sv]
`default_nettype none

`include "utf8_to_utf16_transcoder_defines.svh"

module u8u16_back
  import u8u16_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire op_t                   head,
  input  wire logic                  empty,
  output logic                       pop,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [M_TDATA_W-1:0]       m_tdata,  // [15:0] code_unit, [31:16] char_byte_offset,
                                               // [47:32] unit_index, [48] run_last, zero pad
  output logic                       m_tuser,  // is_error
  output logic                       m_tlast   // string_done
);

  logic              phase;      // 1 while the low surrogate is due
  logic              load;
  logic              take;
  logic              last_of_op;
  logic [UNIT_W-1:0] unit_sel;
  logic [POS_W-1:0]  index_sel;

  assign load       = !m_tvalid || m_tready;
  assign take       = load && !empty;
  assign last_of_op = !head.pair || phase;
  assign pop        = take && last_of_op;
  assign unit_sel   = phase ? head.unit_lo : head.unit_hi;
  assign index_sel  = phase ? pos_inc(head.index) : head.index;

  // output valid and pair phase
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      phase    <= 1'b0;
    end else if (load) begin
      m_tvalid <= !empty;
      if (take) phase <= !last_of_op;
    end
  end

  // output item register
  always_ff @(posedge clk) begin
    if (take) begin
      m_tdata <= {7'b0000000, last_of_op, pos_field(index_sel),
                  pos_field(head.offset), unit_sel};
      m_tuser <= head.err;
      m_tlast <= last_of_op && head.eos;
    end
  end

  // a half-sent pair keeps its entry at the queue head
  `U8U16_ASSERT_NOW(a_phase_has_head, clk, rst, phase, !empty && head.pair)
  // an error result is always the last one of its byte
  `U8U16_ASSERT_NOW(a_err_run_last, clk, rst, m_tvalid && m_tuser, m_tdata[48])
  // end of string falls on the last result of a byte
  `U8U16_ASSERT_NOW(a_done_run_last, clk, rst, m_tvalid && m_tlast, m_tdata[48])
  // after a high surrogate goes out, the low one follows
  `U8U16_ASSERT_NEXT(a_pair_follows, clk, rst, take && !last_of_op, phase)

endmodule

`default_nettype wire
